// File: sv/event_fragment_builder_defines.svh
// Assertion macros for the event fragment builder.
`ifndef EVENT_FRAGMENT_BUILDER_DEFINES_SVH
`define EVENT_FRAGMENT_BUILDER_DEFINES_SVH
// Same-cycle implication.
`define EFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define EFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/efb_pkg.sv
// Types and constants shared by the event fragment builder.
package efb_pkg;
  localparam int unsigned TRIG_W = 28;
  localparam int unsigned FRAG_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned NODE_W = 8;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUILDER_TAG = 8'd1;

  localparam logic [FRAG_W-1:0] FRAG_MAX = 8'hff;
  localparam logic [LEN_W-1:0]  LEN_MAX  = 16'hffff;

  typedef struct packed {
    logic [TRIG_W-1:0] trig;
    logic [FRAG_W-1:0] frags;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic [TRIG_W-1:0] event_trig;
    logic [FRAG_W-1:0] fragment_count;
    logic [LEN_W-1:0]  total_length;
    logic              complete;
    logic [TAG_W-1:0]  source_tag;
    logic              last;
  } result_t;
endpackage

// File: sv/efb_table.sv
// Pending event table memory kept in arrival order, one write and one registered read port.
module efb_table import efb_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [IW-1:0] raddr_i,
  output entry_t        rdata_o
);
  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/efb_out.sv
// Output register stage for emitted event headers.
module efb_out import efb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);
  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: sv/event_fragment_builder.sv
// Event fragment builder top level: sequencer over the pending table.
// Usage: fragment descriptors arrive on the in_* request channel (valid/ready).
// Each request searches the pending table, one entry at a time, for a
// matching trigger number; a hit updates the fragment count and length.
// When an entry reaches the node count, a compaction pass walks the whole
// table entry by entry, emitting every older entry with trigger number
// not above it and the entry itself (last set), and packing the remainder.
// A full table evicts its oldest entry with the same pass, then stores.
// in_ready_o is high only while the sequencer is idle.
// Headers leave on out_* through an output register; a stalled receiver
// holds the pass at the entry waiting to be emitted.
// cfg_* writes node_count (index 0) or builder_tag (index 1); always ready.
// Reset empties the table and sets node_count to 1, builder_tag to 0.
module event_fragment_builder import efb_pkg::*; #(
  parameter int unsigned PENDING_DEPTH = 16,
  parameter int unsigned MAX_NODES = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [NODE_W-1:0]    in_node_id_i,
  input  logic [TRIG_W-1:0]    in_trigger_number_i,
  input  logic [LEN_W-1:0]     in_fragment_bytes_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TRIG_W-1:0]    out_event_trig_o,
  output logic [FRAG_W-1:0]    out_fragment_count_o,
  output logic [LEN_W-1:0]     out_total_length_o,
  output logic                 out_complete_o,
  output logic [TAG_W-1:0]     out_source_tag_o,
  output logic                 out_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TAG_W-1:0]     cfg_data_i
);
  localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(PENDING_DEPTH);
  localparam logic [FRAG_W-1:0] MAXN = FRAG_W'(MAX_NODES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SCHK = 3'd2;
  localparam logic [2:0] ST_MISS = 3'd3;
  localparam logic [2:0] ST_APND = 3'd4;
  localparam logic [2:0] ST_FRD  = 3'd5;
  localparam logic [2:0] ST_FPRC = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     r_q, r_d, top_q, top_d;
  logic [CW-1:0]     w_q, w_d;
  logic              evict_q, evict_d;
  logic [TRIG_W-1:0] trig_q;
  logic [LEN_W-1:0]  bytes_q;
  logic [FRAG_W-1:0] node_count_q;
  logic [TAG_W-1:0]  tag_q;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata, rdata;
  logic          load, out_free;
  result_t       res, out_data;
  logic [FRAG_W-1:0] eff, nfrag;
  logic [LEN_W:0]    lsum;
  logic [LEN_W-1:0]  nlen;
  logic              at_end, drop;

  assign eff = (node_count_q == '0) ? FRAG_W'(1) :
               ((node_count_q > MAXN) ? MAXN : node_count_q);
  assign nfrag = (rdata.frags == FRAG_MAX) ? rdata.frags : rdata.frags + FRAG_W'(1);
  assign lsum = {1'b0, rdata.len} + {1'b0, bytes_q};
  assign nlen = lsum[LEN_W] ? LEN_MAX : lsum[LEN_W-1:0];
  assign at_end = (CW'(r_q) + CW'(1)) == cnt_q;
  assign drop = evict_q ? (r_q == '0) : ((r_q <= top_q) && (rdata.trig <= trig_q));
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    top_d   = top_q;
    w_d     = w_q;
    evict_d = evict_q;
    we      = 1'b0;
    waddr   = r_q;
    wdata   = rdata;
    load    = 1'b0;
    res     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          r_d = '0;
          state_d = (cnt_q == '0) ? ST_MISS : ST_SRD;
        end
      end
      ST_SRD: state_d = ST_SCHK;
      ST_SCHK: begin
        if (rdata.trig == trig_q) begin
          we = 1'b1;
          wdata = '{trig: rdata.trig, frags: nfrag, len: nlen};
          if (nfrag >= eff) begin
            top_d = r_q;
            r_d = '0;
            w_d = '0;
            evict_d = 1'b0;
            state_d = ST_FRD;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (at_end) begin
          state_d = ST_MISS;
        end else begin
          r_d = r_q + IW'(1);
          state_d = ST_SRD;
        end
      end
      ST_MISS: begin
        if (eff <= FRAG_W'(1)) begin
          if (out_free) begin
            load = 1'b1;
            res = '{event_trig: trig_q, fragment_count: FRAG_W'(1),
                    total_length: bytes_q, complete: 1'b1, source_tag: tag_q,
                    last: 1'b1};
            state_d = ST_IDLE;
          end
        end else if (cnt_q == FULL) begin
          r_d = '0;
          w_d = '0;
          evict_d = 1'b1;
          state_d = ST_FRD;
        end else begin
          state_d = ST_APND;
        end
      end
      ST_APND: begin
        we = 1'b1;
        waddr = cnt_q[IW-1:0];
        wdata = '{trig: trig_q, frags: FRAG_W'(1), len: bytes_q};
        cnt_d = cnt_q + CW'(1);
        state_d = ST_IDLE;
      end
      ST_FRD: state_d = ST_FPRC;
      ST_FPRC: begin
        if (!drop || out_free) begin
          if (drop) begin
            load = 1'b1;
            res = '{event_trig: rdata.trig, fragment_count: rdata.frags,
                    total_length: rdata.len, complete: (rdata.frags >= eff),
                    source_tag: tag_q, last: (evict_q || (r_q == top_q))};
          end else begin
            we = 1'b1;
            waddr = w_q[IW-1:0];
            wdata = rdata;
            w_d = w_q + CW'(1);
          end
          if (at_end) begin
            cnt_d = w_d;
            state_d = evict_q ? ST_APND : ST_IDLE;
          end else begin
            r_d = r_q + IW'(1);
            state_d = ST_FRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      node_count_q <= FRAG_W'(1);
      tag_q        <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_index_i == CFG_NODE_COUNT) node_count_q <= cfg_data_i[FRAG_W-1:0];
      if (cfg_valid_i && cfg_index_i == CFG_BUILDER_TAG) tag_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    top_q   <= top_d;
    w_q     <= w_d;
    evict_q <= evict_d;
    if (in_valid_i && in_ready_o) begin
      trig_q  <= in_trigger_number_i;
      bytes_q <= in_fragment_bytes_i;
    end
  end

  efb_table #(.DEPTH(PENDING_DEPTH), .IW(IW)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (r_q),
    .rdata_o (rdata)
  );

  efb_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .data_i  (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign out_event_trig_o     = out_data.event_trig;
  assign out_fragment_count_o = out_data.fragment_count;
  assign out_total_length_o   = out_data.total_length;
  assign out_complete_o       = out_data.complete;
  assign out_source_tag_o     = out_data.source_tag;
  assign out_last_o           = out_data.last;
endmodule

// File: sv/efb_checker.sv
// Port-level checker for the event fragment builder, bound to the top level.
`include "event_fragment_builder_defines.svh"
module efb_checker import efb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [TRIG_W-1:0] out_event_trig_o,
  input logic [FRAG_W-1:0] out_fragment_count_o,
  input logic              out_last_o
);
  `EFB_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  `EFB_ASSERT_NOW(a_busy_mid_flush, out_valid_o && !out_last_o, !in_ready_o)
  `EFB_ASSERT_NOW(a_nonzero_frags, out_valid_o, out_fragment_count_o != '0)
  `EFB_ASSERT_NEXT(a_hold_stalled, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_event_trig_o))
endmodule

bind event_fragment_builder efb_checker u_efb_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .out_event_trig_o     (out_event_trig_o),
  .out_fragment_count_o (out_fragment_count_o),
  .out_last_o           (out_last_o)
);
